// ===== design/dtg_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
package dtg_pkg;

    localparam int DENSITY_BITS = 16;
    // Divisor register must also hold 1.0 in Q8.8 (256).
    localparam int DIV_W        = (DENSITY_BITS > 9) ? DENSITY_BITS : 9;
    localparam int VEL_W        = 16;
    localparam int PIX_W        = 8;
    localparam int Q_BITS       = 16;
    localparam int CNT_W        = $clog2(Q_BITS);
    localparam int ROOT_REM_W   = Q_BITS + 2;

    localparam logic [DIV_W-1:0] ONE_Q88   = DIV_W'(256);
    localparam logic [PIX_W-1:0] PIX_FULL  = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_ZERO  = '0;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY_GAMMA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_SOLID  = 1'b1;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic root_step;
        logic load_out;
    } dtg_cmd_t;

    typedef struct packed {
        logic is_convert;
        logic is_short;
        logic apply_gamma;
    } dtg_status_t;

endpackage

// ===== design/dtg_ctrl.sv =====
// Controller: sequences the divide and square-root steps and owns the handshakes.
module dtg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  dtg_pkg::dtg_status_t status,
    output dtg_pkg::dtg_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [dtg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      last_step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign last_step = (cnt_reg == dtg_pkg::CNT_W'(dtg_pkg::Q_BITS - 1));

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.accept    = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && status.is_convert) begin
                    cnt_next   = '0;
                    state_next = status.is_short ? ST_DONE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step) begin
                    cnt_next   = '0;
                    state_next = status.apply_gamma ? ST_ROOT : ST_DONE;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/dtg_datapath.sv =====
// Datapath: frame maximum, configuration, restoring divider, digit square root, pixel register.
module dtg_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dtg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic                                cfg_wdata,
    input  logic                                s_mode,
    input  logic [dtg_pkg::DENSITY_BITS-1:0]    s_density,
    input  logic signed [dtg_pkg::VEL_W-1:0]    s_vel_x,
    input  logic signed [dtg_pkg::VEL_W-1:0]    s_vel_y,
    input  logic                                s_last_cell,
    input  dtg_pkg::dtg_cmd_t                   cmd,
    output dtg_pkg::dtg_status_t                status,
    output logic [dtg_pkg::PIX_W-1:0]           m_red,
    output logic [dtg_pkg::PIX_W-1:0]           m_green,
    output logic [dtg_pkg::PIX_W-1:0]           m_blue,
    output logic                                m_last_pixel
);

    localparam int DW = dtg_pkg::DIV_W;
    localparam int QW = dtg_pkg::Q_BITS;
    localparam int RW = dtg_pkg::ROOT_REM_W;
    localparam int PW = dtg_pkg::PIX_W;

    logic                             apply_gamma_reg, apply_gamma_next;
    logic                             mark_solid_reg, mark_solid_next;
    logic [dtg_pkg::DENSITY_BITS-1:0] running_max_reg, running_max_next;
    logic [DW-1:0]                    frame_divisor_reg, frame_divisor_next;

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [QW-1:0] root_reg, root_next;
    logic [RW-1:0] root_rem_reg, root_rem_next;
    logic          solid_reg, solid_next;
    logic          sat_reg, sat_next;
    logic          last_reg, last_next;

    logic [PW-1:0] red_reg, red_next;
    logic [PW-1:0] green_reg, green_next;
    logic [PW-1:0] blue_reg, blue_next;
    logic          last_pixel_reg, last_pixel_next;

    logic [DW-1:0]                    density_ext;
    logic [dtg_pkg::DENSITY_BITS-1:0] max_upd;
    logic                             is_solid;
    logic                             is_sat;
    logic [DW:0]                      div_shift;
    logic [DW:0]                      div_diff;
    logic                             div_ge;
    logic [RW+1:0]                    root_acc;
    logic [RW+1:0]                    root_trial;
    logic                             root_ge;
    logic [QW-1:0]                    s_val;
    logic [QW+PW-1:0]                 scaled;
    logic [PW-1:0]                    gray;

    assign density_ext = DW'(s_density);
    assign max_upd     = (s_density > running_max_reg) ? s_density : running_max_reg;
    assign is_solid    = mark_solid_reg && (s_density == '0) && (s_vel_x == '0)
                         && (s_vel_y == '0);
    // d >= divisor puts the quotient at or above 1.0: full scale
    assign is_sat      = (density_ext >= frame_divisor_reg);

    assign status.is_convert  = (s_mode == dtg_pkg::MODE_CONVERT);
    assign status.is_short    = is_solid || is_sat;
    assign status.apply_gamma = apply_gamma_reg;

    // one restoring divide step
    assign div_shift = {rem_reg, 1'b0};
    assign div_diff  = div_shift - {1'b0, frame_divisor_reg};
    assign div_ge    = (div_shift >= {1'b0, frame_divisor_reg});

    // one square-root digit; radicand pairs come off the top of q
    assign root_acc   = {root_rem_reg, q_reg[QW-1 -: 2]};
    assign root_trial = (RW+2)'({root_reg, 2'b01});
    assign root_ge    = (root_acc >= root_trial);

    // gray = floor(s * 255 / 65536)
    assign s_val  = apply_gamma_reg ? root_reg : q_reg;
    assign scaled = {s_val, {PW{1'b0}}} - (QW+PW)'(s_val);
    assign gray   = scaled[QW+PW-1 -: PW];

    always_comb begin
        apply_gamma_next   = apply_gamma_reg;
        mark_solid_next    = mark_solid_reg;
        running_max_next   = running_max_reg;
        frame_divisor_next = frame_divisor_reg;
        rem_next           = rem_reg;
        q_next             = q_reg;
        root_next          = root_reg;
        root_rem_next      = root_rem_reg;
        solid_next         = solid_reg;
        sat_next           = sat_reg;
        last_next          = last_reg;
        red_next           = red_reg;
        green_next         = green_reg;
        blue_next          = blue_reg;
        last_pixel_next    = last_pixel_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                dtg_pkg::CFG_APPLY_GAMMA: apply_gamma_next = cfg_wdata;
                dtg_pkg::CFG_MARK_SOLID:  mark_solid_next  = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.accept) begin
            if (s_mode == dtg_pkg::MODE_MEASURE) begin
                running_max_next = max_upd;
                if (s_last_cell) begin
                    frame_divisor_next = (max_upd == '0) ? dtg_pkg::ONE_Q88 : DW'(max_upd);
                    running_max_next   = '0;
                end
            end else begin
                rem_next      = density_ext;
                q_next        = '0;
                root_next     = '0;
                root_rem_next = '0;
                solid_next    = is_solid;
                sat_next      = is_sat;
                last_next     = s_last_cell;
            end
        end

        if (cmd.div_step) begin
            rem_next = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
            q_next   = {q_reg[QW-2:0], div_ge};
        end

        if (cmd.root_step) begin
            q_next        = {q_reg[QW-3:0], 2'b00};
            root_rem_next = root_ge ? RW'(root_acc - root_trial) : root_acc[RW-1:0];
            root_next     = {root_reg[QW-2:0], root_ge};
        end

        if (cmd.load_out) begin
            last_pixel_next = last_reg;
            if (solid_reg) begin
                red_next   = dtg_pkg::PIX_FULL;
                green_next = dtg_pkg::PIX_ZERO;
                blue_next  = dtg_pkg::PIX_ZERO;
            end else if (sat_reg) begin
                red_next   = dtg_pkg::PIX_FULL;
                green_next = dtg_pkg::PIX_FULL;
                blue_next  = dtg_pkg::PIX_FULL;
            end else begin
                red_next   = gray;
                green_next = gray;
                blue_next  = gray;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apply_gamma_reg   <= 1'b1;
            mark_solid_reg    <= 1'b1;
            running_max_reg   <= '0;
            frame_divisor_reg <= dtg_pkg::ONE_Q88;
        end else begin
            apply_gamma_reg   <= apply_gamma_next;
            mark_solid_reg    <= mark_solid_next;
            running_max_reg   <= running_max_next;
            frame_divisor_reg <= frame_divisor_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        root_reg       <= root_next;
        root_rem_reg   <= root_rem_next;
        solid_reg      <= solid_next;
        sat_reg        <= sat_next;
        last_reg       <= last_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        last_pixel_reg <= last_pixel_next;
    end

    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_last_pixel = last_pixel_reg;

endmodule

// ===== design/density_to_gray_normalizer.sv =====
// Top level of the density-to-grayscale normaliser: controller plus datapath.
//
// Each item is a density cell. A measure item (mode 0) never makes the block
// busy: the running maximum is updated as the item is accepted, no pixel comes
// out, and a cell marked last freezes the maximum as the frame divisor (1.0 if
// the frame was all zero) and clears the running value. Before any measure
// pass the divisor is 1.0. A convert item (mode 1) gives exactly one pixel.
// Solid cells (zero density and velocity, with solid marking on) and cells at
// or above the divisor skip the arithmetic and go straight to the output step.
// Other cells run a 16-step restoring divider, one quotient bit a cycle, and
// with gamma on a 16-step digit-by-digit square root after it, both paced by
// the step counter of the controller. Results leave through a registered
// output; one finished pixel may wait there while the next item is accepted
// and worked on, and the block stalls only in its last step until that
// register is taken. Configuration writes are registered and are meant for
// when the block is idle.
module density_to_gray_normalizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dtg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic                                cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [dtg_pkg::DENSITY_BITS-1:0]    s_density,
    input  logic signed [dtg_pkg::VEL_W-1:0]    s_vel_x,
    input  logic signed [dtg_pkg::VEL_W-1:0]    s_vel_y,
    input  logic                                s_last_cell,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dtg_pkg::PIX_W-1:0]           m_red,
    output logic [dtg_pkg::PIX_W-1:0]           m_green,
    output logic [dtg_pkg::PIX_W-1:0]           m_blue,
    output logic                                m_last_pixel
);

    // command and status between controller and datapath
    dtg_pkg::dtg_cmd_t    cmd;
    dtg_pkg::dtg_status_t status;

    dtg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dtg_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_mode       (s_mode),
        .s_density    (s_density),
        .s_vel_x      (s_vel_x),
        .s_vel_y      (s_vel_y),
        .s_last_cell  (s_last_cell),
        .cmd          (cmd),
        .status       (status),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_last_pixel (m_last_pixel)
    );

endmodule

// ===== design/dtg_checker.sv =====
// Port-level checker for the normaliser, bound to the top level.
module dtg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_mode,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [dtg_pkg::PIX_W-1:0]           m_red,
    input logic [dtg_pkg::PIX_W-1:0]           m_green,
    input logic [dtg_pkg::PIX_W-1:0]           m_blue,
    input logic                                m_last_pixel
);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_last_pixel))
        else $error("pixel changed while stalled");

    // a measure item never produces a pixel
    a_measure_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == dtg_pkg::MODE_MEASURE) |=> !$rose(m_valid))
        else $error("pixel after measure item");

    // a convert item keeps the block busy after it is accepted
    a_convert_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == dtg_pkg::MODE_CONVERT) |=> !s_ready)
        else $error("input taken during conversion");

    // pixels are gray or pure red
    a_pixel_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_green == m_blue) && ((m_red == m_green)
            || (m_red == dtg_pkg::PIX_FULL && m_green == dtg_pkg::PIX_ZERO)))
        else $error("pixel neither gray nor solid red");

endmodule

bind density_to_gray_normalizer dtg_checker u_dtg_checker (.*);

// ===== tb/sv/dtg_pixel_checker.sv =====
// Pixel checker for the density-to-grayscale normaliser: predicts each pixel and compares it.
module dtg_pixel_checker
    import dtg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic                    cfg_wdata,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_mode,
    input  logic [DENSITY_BITS-1:0] s_density,
    input  logic [VEL_W-1:0]        s_vel_x,
    input  logic [VEL_W-1:0]        s_vel_y,
    input  logic                    s_last_cell,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [PIX_W-1:0]        m_red,
    input  logic [PIX_W-1:0]        m_green,
    input  logic [PIX_W-1:0]        m_blue,
    input  logic                    m_last_pixel,
    output int                      fail_count,
    output int                      pixels_waiting,
    output int                      pixels_checked
);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } pixel_t;

    pixel_t                  pending_pixels[$];
    logic                    gamma_on;
    logic                    solid_on;
    logic [DENSITY_BITS-1:0] peak_density;
    logic [DIV_W-1:0]        frame_scale;

    // Largest r with r*r <= x, built one result bit at a time from the top.
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned trial;
        for (int b = Q_BITS; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    function automatic pixel_t shade_cell(logic [DENSITY_BITS-1:0] d,
                                          logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                          logic last);
        pixel_t          px;
        longint unsigned scale, q, s, g;
        px.last = last;
        if (solid_on && d == '0 && vx == '0 && vy == '0) begin
            px.red   = PIX_FULL;
            px.green = PIX_ZERO;
            px.blue  = PIX_ZERO;
            return px;
        end
        scale = (frame_scale == '0) ? longint'(ONE_Q88) : longint'(frame_scale);
        q = (longint'(d) << Q_BITS) / scale;
        if (q > 65536)
            q = 65536;
        s = gamma_on ? root_floor(q << Q_BITS) : q;
        g = (s * 255) >> Q_BITS;
        if (g > 255)
            g = 255;
        px.red   = PIX_W'(g);
        px.green = PIX_W'(g);
        px.blue  = PIX_W'(g);
        return px;
    endfunction

    task automatic check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        pixel_t want;
        if (!aresetn) begin
            gamma_on       = 1'b1;
            solid_on       = 1'b1;
            peak_density   = '0;
            frame_scale    = ONE_Q88;
            fail_count     = 0;
            pixels_checked = 0;
            pending_pixels.delete();
        end else begin
            // Retire the outgoing pixel first: it always belongs to an older item.
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: pixel with none expected, got r=%0d g=%0d b=%0d last=%0b",
                             $time, m_red, m_green, m_blue, m_last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("last", PIX_W'(want.last), PIX_W'(m_last_pixel));
                end
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_MEASURE) begin
                    if (s_density > peak_density)
                        peak_density = s_density;
                    if (s_last_cell) begin
                        frame_scale  = (peak_density == '0) ? ONE_Q88 : DIV_W'(peak_density);
                        peak_density = '0;
                    end
                end else begin
                    pending_pixels.push_back(shade_cell(s_density, s_vel_x, s_vel_y,
                                                        s_last_cell));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_APPLY_GAMMA: gamma_on = cfg_wdata;
                    CFG_MARK_SOLID:  solid_on = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pixels_waiting = pending_pixels.size();
    end

endmodule

// ===== tb/sv/tb_density_to_gray_normalizer.sv =====
// Testbench top for the density-to-grayscale normaliser: stimulus, stalls and verdict.
module tb_density_to_gray_normalizer;
    import dtg_pkg::*;

    // Settling time after a drain, longer than a gamma convert item, the longest kind.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_CELLS  = 2000;
    localparam int PHASES        = 8;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = CFG_APPLY_GAMMA;
    logic                    cfg_wdata   = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_mode      = MODE_MEASURE;
    logic [DENSITY_BITS-1:0] s_density   = '0;
    logic [VEL_W-1:0]        s_vel_x     = '0;
    logic [VEL_W-1:0]        s_vel_y     = '0;
    logic                    s_last_cell = 1'b0;
    logic                    m_ready     = 1'b0;
    logic                    s_ready;
    logic                    m_valid;
    logic [PIX_W-1:0]        m_red, m_green, m_blue;
    logic                    m_last_pixel;

    int fail_count, pixels_waiting, pixels_checked;
    bit idle_on       = 1'b1;
    int cells_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;

    always #5 aclk = ~aclk;

    density_to_gray_normalizer u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_density    (s_density),
        .s_vel_x      (s_vel_x),
        .s_vel_y      (s_vel_y),
        .s_last_cell  (s_last_cell),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_last_pixel (m_last_pixel)
    );

    dtg_pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_density      (s_density),
        .s_vel_x        (s_vel_x),
        .s_vel_y        (s_vel_y),
        .s_last_cell    (s_last_cell),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_last_pixel   (m_last_pixel),
        .fail_count     (fail_count),
        .pixels_waiting (pixels_waiting),
        .pixels_checked (pixels_checked)
    );

    // Pixel sink: random runs of ready mixed with random stall bursts.
    // Once idling is switched off, hold ready high for good.
    always begin : pixel_sink
        int run;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            run = $urandom_range(1, 18);
            repeat (run) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
        end else begin
            run = $urandom_range(1, 40);
            repeat (run) begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Offer one cell and hold it until the block takes it. An optional random
    // idle gap comes first; valid is only lowered inside that gap, so
    // back-to-back items keep valid high without a glitch.
    task automatic send_cell(logic mode, logic [DENSITY_BITS-1:0] d,
                             logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy, logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_density   <= d;
        s_vel_x     <= vx;
        s_vel_y     <= vy;
        s_last_cell <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        cells_sent++;
    endtask

    // Drop valid, wait for every predicted pixel, then let the block settle.
    task automatic drain_pixels();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixels_waiting != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_shading(logic gamma, logic solid);
        write_reg(CFG_APPLY_GAMMA, gamma);
        write_reg(CFG_MARK_SOLID, solid);
        settings_used++;
    endtask

    function automatic logic [VEL_W-1:0] pick_velocity();
        case ($urandom_range(0, 3))
            0, 1:    return '0;
            2:       return VEL_W'($urandom);
            default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function automatic logic [DENSITY_BITS-1:0] pick_frame_peak();
        case ($urandom_range(0, 4))
            0:       return DENSITY_BITS'($urandom);
            1:       return DENSITY_BITS'($urandom_range(0, 16'h01FF));
            2:       return DENSITY_BITS'($urandom_range(16'hFF00, 16'hFFFF));
            3:       return '0;
            default: return DENSITY_BITS'($urandom_range(0, 16'h0FFF));
        endcase
    endfunction

    // One frame: a measure pass that sets the divisor, then a convert pass over
    // the same number of cells. Now and then the measure pass is left open.
    task automatic run_frame(int cells);
        logic [DENSITY_BITS-1:0] peak, d;
        logic [VEL_W-1:0]        vx, vy;
        int                      peak_at;
        bit                      close_pass;
        peak       = pick_frame_peak();
        peak_at    = $urandom_range(0, cells - 1);
        close_pass = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < cells; i++) begin
            d = (i == peak_at) ? peak : DENSITY_BITS'($urandom_range(0, peak));
            send_cell(MODE_MEASURE, d, pick_velocity(), pick_velocity(),
                      close_pass && i == cells - 1);
        end
        for (int i = 0; i < cells; i++) begin
            vx = pick_velocity();
            vy = pick_velocity();
            case ($urandom_range(0, 7))
                0: begin
                    d  = '0;
                    vx = '0;
                    vy = '0;
                end
                1:       d = DENSITY_BITS'($urandom);
                default: d = DENSITY_BITS'($urandom_range(0, peak));
            endcase
            send_cell(MODE_CONVERT, d, vx, vy, i == cells - 1);
        end
        frames_sent++;
    endtask

    // Unstructured cells: any mode, any field, last flags anywhere.
    task automatic run_noise(int cells);
        repeat (cells)
            send_cell($urandom_range(0, 1) ? MODE_CONVERT : MODE_MEASURE,
                      DENSITY_BITS'($urandom), VEL_W'($urandom), pick_velocity(),
                      $urandom_range(0, 1));
    endtask

    initial begin : stimulus
        int  phase_goal;
        int  roll;
        bit  gamma, solid;
        repeat (11)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Divisor still 1.0 from reset: solid red, half scale, exactly the divisor,
        // far above it (saturates), and zero density with a moving cell.
        send_cell(MODE_CONVERT, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'h0080, 16'h7FFF, 16'h8000, 1'b0);
        send_cell(MODE_CONVERT, 16'h0100, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_cell(MODE_CONVERT, 16'h0000, 16'h0001, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'h0000, 16'h0000, 16'h8000, 1'b1);
        // Measure pass peaking at full scale.
        send_cell(MODE_MEASURE, 16'h1234, 16'h7FFF, 16'h0000, 1'b0);
        send_cell(MODE_MEASURE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_MEASURE, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_cell(MODE_CONVERT, 16'hFFFF, 16'h0000, 16'h0001, 1'b0);
        send_cell(MODE_CONVERT, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // A last flag in the convert pass must leave the divisor alone.
        send_cell(MODE_CONVERT, 16'h8000, 16'h0001, 16'h0001, 1'b0);
        // All-zero frame falls back to 1.0.
        send_cell(MODE_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_cell(MODE_CONVERT, 16'h0080, 16'h0000, 16'h0000, 1'b0);
        // Small divisor, density above it.
        send_cell(MODE_MEASURE, 16'h0010, 16'h0000, 16'h0000, 1'b1);
        send_cell(MODE_CONVERT, 16'h0020, 16'h0000, 16'h0000, 1'b1);
        // Linear shading with solid marking off: a solid cell is plain gray 0.
        drain_pixels();
        set_shading(1'b0, 1'b0);
        send_cell(MODE_CONVERT, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_cell(MODE_CONVERT, 16'h0008, 16'h0000, 16'h0000, 1'b0);
        send_cell(MODE_CONVERT, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);

        // Random phases, each under its own shading setting; the first four
        // visit every corner, the last runs without any idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pixels();
            case (phase)
                0: begin gamma = 1'b1; solid = 1'b1; end
                1: begin gamma = 1'b0; solid = 1'b0; end
                2: begin gamma = 1'b0; solid = 1'b1; end
                3: begin gamma = 1'b1; solid = 1'b0; end
                default: begin
                    gamma = $urandom_range(0, 1);
                    solid = $urandom_range(0, 1);
                end
            endcase
            set_shading(gamma, solid);
            idle_on    = (phase < PHASES - 1);
            phase_goal = cells_sent + RANDOM_CELLS / PHASES;
            while (cells_sent < phase_goal) begin
                roll = $urandom_range(0, 19);
                if (roll < 2)
                    run_noise($urandom_range(1, 6));
                else if (roll == 2 && idle_on)
                    drain_pixels();
                else
                    run_frame($urandom_range(1, 12));
            end
        end

        drain_pixels();
        $display("Run covered %0d cells in %0d random frames, %0d pixels checked,",
                 cells_sent, frames_sent, pixels_checked);
        $display("across %0d shading settings of gamma and solid marking.", settings_used);
        if (fail_count == 0)
            $display("PASS density_to_gray_normalizer");
        else
            $display("FAIL density_to_gray_normalizer");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a fifth of this.
    initial begin : watchdog
        #10_000_000;
        $display("FAIL density_to_gray_normalizer");
        $finish;
    end

endmodule
